// ===== sv/dcj_pkg.sv =====
// damped cosine jiggle package: fixed-point constants, polynomial coefficients
// and the rounded q30 multiply shared by the pipeline stages
// no dependencies
package dcj_pkg;

    localparam int unsigned ACC_W = 36;

    localparam logic signed [ACC_W-1:0] ONE_Q30    = 36'sd1073741824;
    localparam logic signed [ACC_W-1:0] TWO_PI_Q28 = 36'sd1686629713;
    localparam logic [32:0]             LOG2E_Q32  = 33'd6196328019;
    localparam logic [31:0]             LN2_Q32    = 32'd2977044472;
    localparam logic [63:0]             DT_LIMIT   = 64'd50 << 32;
    localparam logic [6:0]              M_ZERO     = 7'd62;

    // exp horner: seed, then the value added after each multiply by r
    localparam logic signed [ACC_W-1:0] EXP_SEED = 36'sd8947849;
    localparam logic signed [ACC_W-1:0] EXP_ADD [5] = '{
        36'sd44739243, 36'sd178956971, 36'sd536870912, 36'sd1073741824, 36'sd1073741824
    };

    // cos horner over x squared
    localparam logic signed [ACC_W-1:0] COS_SEED = 36'sd2;
    localparam logic signed [ACC_W-1:0] COS_ADD [6] = '{
        -36'sd296, 36'sd26631, -36'sd1491308, 36'sd44739243, -36'sd536870912,
        36'sd1073741824
    };

    // (a*b) >> 30 rounded half away from zero
    function automatic logic signed [ACC_W-1:0] qmul30(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic [ACC_W-1:0]   ma;
        logic [ACC_W-1:0]   mb;
        logic [2*ACC_W-1:0] p;
        logic [ACC_W-1:0]   q;
        ma = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
        mb = b[ACC_W-1] ? ACC_W'(-b) : ACC_W'(b);
        p  = (2*ACC_W)'(ma) * (2*ACC_W)'(mb);
        p  = p + ((2*ACC_W)'(1) << 29);
        q  = p[ACC_W+29:30];
        return (a[ACC_W-1] ^ b[ACC_W-1]) ? $signed(-q) : $signed(q);
    endfunction

endpackage

// ===== sv/dcj_in_if.sv =====
// input channel of the damped cosine jiggle block
// depends on nothing
interface dcj_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_time;
    logic        [31:0] osc_frequency;
    logic signed [31:0] peak_amplitude;
    logic        [31:0] decay_rate;
    logic               batch_end;

    modport source(output valid, sample_time, osc_frequency, peak_amplitude, decay_rate,
                   batch_end, input ready);
    modport sink(input valid, sample_time, osc_frequency, peak_amplitude, decay_rate,
                 batch_end, output ready);
endinterface

// ===== sv/dcj_out_if.sv =====
// output channel of the damped cosine jiggle block
// depends on nothing
interface dcj_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] displacement;
    logic               batch_end_out;

    modport source(output valid, displacement, batch_end_out, input ready);
    modport sink(input valid, displacement, batch_end_out, output ready);
endinterface

// ===== sv/dcj_mac.sv =====
// one registered multiply-add stage: c + round((a*b) >> 30)
// depends on dcj_pkg
module dcj_mac (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [dcj_pkg::ACC_W-1:0]   i_a,
    input  logic signed [dcj_pkg::ACC_W-1:0]   i_b,
    input  logic signed [dcj_pkg::ACC_W-1:0]   i_c,
    output logic signed [dcj_pkg::ACC_W-1:0]   o_acc
);

    logic signed [dcj_pkg::ACC_W-1:0] r_acc;

    // product and addend registered together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= i_c + dcj_pkg::qmul30(i_a, i_b);
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== sv/damped_cosine_jiggle_top.sv =====
// damped cosine jiggle top level: twelve-stage pipeline with handshake
// depends on dcj_pkg, dcj_in_if, dcj_out_if and dcj_mac

// Computes amplitude * exp(-decay*time) * cos(2*pi*frequency*time) in Q16.16,
// one item per clock cycle, through twelve register stages that end in the output
// register. The envelope and cosine Horner chains run side by side. The whole
// pipe advances together; input ready drops only while a finished result sits
// unclaimed in the output register. Negative times and decay*time above 50 give
// zero.
module damped_cosine_jiggle_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcj_in_if.sink     i_in,
    dcj_out_if.source  o_out
);

    localparam int NSTG = 12;
    localparam int AW   = dcj_pkg::ACC_W;

    logic                 en;
    logic                 r_vld  [1:NSTG];
    logic                 r_kill [1:NSTG];
    logic                 r_bend [1:NSTG];
    logic signed [31:0]   r_amp  [1:10];
    logic        [63:0]   r_e;
    logic        [31:0]   r_ph;
    logic        [37:0]   r_e2;
    logic        [6:0]    r_m    [2:8];
    logic signed [AW-1:0] r_r    [3:7];
    logic signed [AW-1:0] r_xx   [4:8];
    logic signed [AW-1:0] r_env;
    logic signed [31:0]   r_disp;

    logic signed [AW-1:0] w_x;
    logic signed [AW-1:0] w_xx;
    logic signed [AW-1:0] w_xxs  [3:8];
    logic signed [AW-1:0] w_ea   [0:4];
    logic signed [AW-1:0] w_ca   [0:5];
    logic signed [AW-1:0] w_g;
    logic signed [AW-1:0] w_dsp;
    logic signed [AW-1:0] cos_c;

    logic        [63:0]   zs;
    logic        [6:0]    m_nx;
    logic        [38:0]   mln;
    logic signed [39:0]   rv;
    logic        [39:0]   rmag;
    logic        [39:0]   rq;
    logic signed [AW-1:0] n_r;
    logic        [31:0]   y;
    logic        [63:0]   sh;
    logic        [63:0]   envs;
    logic signed [AW-1:0] n_env;
    logic signed [31:0]   n_disp;

    // whole pipe moves unless the output item is held
    assign en          = !r_vld[NSTG] || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_vld[NSTG];
    assign o_out.displacement  = r_disp;
    assign o_out.batch_end_out = r_bend[NSTG];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NSTG; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[1] <= i_in.valid;
            for (int k = 2; k <= NSTG; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // stage 2 envelope split: m = round(e * log2(e))
    always_comb begin
        zs   = 64'(63'(r_e[37:8]) * 63'(dcj_pkg::LOG2E_Q32)) + (64'd1 << 55);
        m_nx = zs[62:56];
    end

    // stage 3 remainder r = m*ln2 - e, rounded to q30
    always_comb begin
        mln  = 39'(r_m[2]) * 39'(dcj_pkg::LN2_Q32);
        rv   = $signed({1'b0, mln}) - $signed({2'b0, r_e2});
        rmag = rv[39] ? 40'(-rv) : 40'(rv);
        rq   = (rmag + 40'd2) >> 2;
        n_r  = rv[39] ? AW'(-$signed(rq)) : AW'($signed(rq));
    end

    // stage 9 envelope scale by 2^-m with rounding and clamp
    always_comb begin
        y    = w_ea[4][AW-1] ? 32'd0 : w_ea[4][31:0];
        sh   = (r_m[8] == 7'd0) ? 64'd0 : (64'd1 << (r_m[8] - 7'd1));
        envs = (64'(y) + sh) >> r_m[8];
        if (r_m[8] >= dcj_pkg::M_ZERO) begin
            n_env = '0;
        end else if (envs > 64'(dcj_pkg::ONE_Q30)) begin
            n_env = dcj_pkg::ONE_Q30;
        end else begin
            n_env = AW'($signed({1'b0, envs[31:0]}));
        end
    end

    // cosine clamp to [-1, 1]
    always_comb begin
        if (w_ca[5] > dcj_pkg::ONE_Q30) begin
            cos_c = dcj_pkg::ONE_Q30;
        end else if (w_ca[5] < -dcj_pkg::ONE_Q30) begin
            cos_c = -dcj_pkg::ONE_Q30;
        end else begin
            cos_c = w_ca[5];
        end
    end

    // final saturation and zeroing
    always_comb begin
        if (r_kill[11]) begin
            n_disp = '0;
        end else if (w_dsp > 36'sd2147483647) begin
            n_disp = 32'sh7FFFFFFF;
        end else begin
            n_disp = w_dsp[31:0];
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e      <= 64'(i_in.decay_rate) * 64'(i_in.sample_time);
            r_ph     <= 32'(64'(i_in.osc_frequency) * 64'(i_in.sample_time));
            r_amp[1] <= i_in.peak_amplitude;
            r_bend[1] <= i_in.batch_end;
            r_kill[1] <= i_in.sample_time[31];
            for (int k = 2; k <= 10; k++) r_amp[k] <= r_amp[k-1];
            for (int k = 2; k <= NSTG; k++) r_bend[k] <= r_bend[k-1];
            for (int k = 3; k <= NSTG; k++) r_kill[k] <= r_kill[k-1];
            r_kill[2] <= r_kill[1] || (r_e > dcj_pkg::DT_LIMIT);
            r_e2     <= r_e[37:0];
            r_m[2]   <= m_nx;
            for (int k = 3; k <= 8; k++) r_m[k] <= r_m[k-1];
            r_r[3]   <= n_r;
            for (int k = 4; k <= 7; k++) r_r[k] <= r_r[k-1];
            r_xx[4]  <= w_xx;
            for (int k = 5; k <= 8; k++) r_xx[k] <= r_xx[k-1];
            r_env    <= n_env;
            r_disp   <= n_disp;
        end
    end

    // cosine argument: phase fraction times 2*pi, then squared
    dcj_mac u_x (
        .i_clk(i_clk), .i_en(en),
        .i_a({{(AW-32){r_ph[31]}}, r_ph}), .i_b(dcj_pkg::TWO_PI_Q28), .i_c('0),
        .o_acc(w_x)
    );

    dcj_mac u_xx (
        .i_clk(i_clk), .i_en(en), .i_a(w_x), .i_b(w_x), .i_c('0), .o_acc(w_xx)
    );

    assign w_xxs[3] = w_xx;
    for (genvar k = 4; k <= 8; k++) begin : g_xxs
        assign w_xxs[k] = r_xx[k];
    end

    // exp horner chain, stages 4 to 8
    for (genvar j = 0; j < 5; j++) begin : g_exp
        if (j == 0) begin : g_first
            dcj_mac u_step (
                .i_clk(i_clk), .i_en(en), .i_a(r_r[3]), .i_b(dcj_pkg::EXP_SEED),
                .i_c(dcj_pkg::EXP_ADD[0]), .o_acc(w_ea[0])
            );
        end else begin : g_next
            dcj_mac u_step (
                .i_clk(i_clk), .i_en(en), .i_a(r_r[3+j]), .i_b(w_ea[j-1]),
                .i_c(dcj_pkg::EXP_ADD[j]), .o_acc(w_ea[j])
            );
        end
    end

    // cos horner chain, stages 4 to 9
    for (genvar j = 0; j < 6; j++) begin : g_cos
        if (j == 0) begin : g_first
            dcj_mac u_step (
                .i_clk(i_clk), .i_en(en), .i_a(w_xxs[3]), .i_b(dcj_pkg::COS_SEED),
                .i_c(dcj_pkg::COS_ADD[0]), .o_acc(w_ca[0])
            );
        end else begin : g_next
            dcj_mac u_step (
                .i_clk(i_clk), .i_en(en), .i_a(w_xxs[3+j]), .i_b(w_ca[j-1]),
                .i_c(dcj_pkg::COS_ADD[j]), .o_acc(w_ca[j])
            );
        end
    end

    // envelope times cosine, then amplitude
    dcj_mac u_g (
        .i_clk(i_clk), .i_en(en), .i_a(r_env), .i_b(cos_c), .i_c('0), .o_acc(w_g)
    );

    dcj_mac u_dsp (
        .i_clk(i_clk), .i_en(en), .i_a(AW'(r_amp[10])), .i_b(w_g), .i_c('0),
        .o_acc(w_dsp)
    );

    // checks
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[1])
        else $error("accepted item missing from first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> r_vld[NSTG] && $stable(r_disp))
        else $error("pipe moved while stalled");

    a_kill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG] && r_kill[NSTG] |-> r_disp == 32'sd0)
        else $error("cut-off item gave non-zero result");

    a_env_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[9] |-> (r_env >= 0) && (r_env <= dcj_pkg::ONE_Q30))
        else $error("envelope out of range");

endmodule
